### rtl/afht_pkg.sv
// Package for the address flag hash table: widths, hash constants, action codes
// and the state encoding of the top level; the hash unit imports it as well.
// No dependencies.
package afht_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;

    localparam logic [63:0] FNV_OFFSET = 64'd1469598103934665603;
    localparam logic [63:0] FNV_PRIME  = 64'd1099511628211;
    localparam logic [63:0] MIX_MULT   = 64'hd6e8feb86659fd93;
    localparam logic [3:0]  MAX_LOG2   = 4'd15;
    localparam logic [3:0]  MIN_LOG2   = 4'd4;
    localparam logic [3:0]  RESET_LOG2 = 4'd10;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_COMMIT = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_HASH  = 8'b0000_0010,
        S_READ  = 8'b0000_0100,
        S_CMP   = 8'b0000_1000,
        S_WRITE = 8'b0001_0000,
        S_SWEEP = 8'b0010_0000,
        S_OUT   = 8'b0100_0000,
        S_WAIT  = 8'b1000_0000
    } t_state;

    // Handshake between the sequencer and the hash unit.
    typedef struct packed {
        logic start;
    } t_hash_req;

    typedef struct packed {
        logic        done;
        logic [63:0] hash;
    } t_hash_rsp;

endpackage

### rtl/afht_hash.sv
// Iterative FNV-1a style 64-bit hash (FNV prime, non-standard offset basis) with finaliser over the 160-bit address.
// Each byte fold is an xor, then a 64x64 low multiply built from three
// passes through one shared 32x32 multiplier. Depends on afht_pkg.
module afht_hash (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  afht_pkg::t_hash_req i_req,
    input  logic [159:0]        i_key,
    output afht_pkg::t_hash_rsp o_rsp
);
    import afht_pkg::*;

    // Phase: 0 xor, 1 low by low, 2 low by high, 3 high by low. The last pass of the
    // finaliser also applies the closing xor-shift.
    logic         r_busy, n_busy;
    logic [4:0]   r_byte, n_byte;
    logic [1:0]   r_ph, n_ph;
    logic [1:0]   r_fin, n_fin;
    logic [63:0]  r_h, n_h;
    logic [63:0]  r_acc, n_acc;
    logic [63:0]  r_mul, n_mul;
    logic         r_done, n_done;
    logic [7:0]   w_byte;
    logic [63:0]  w_pp;
    logic [31:0]  w_a;
    logic [31:0]  w_b;
    logic [63:0]  w_sum;

    // Byte picked most significant first.
    assign w_byte = i_key[8'(159 - 8 * r_byte) -: 8];

    // Shared 32x32 multiplier; the operand halves depend on the pass.
    always_comb begin
        case (r_ph)
            2'd2: begin
                w_a = r_h[31:0];
                w_b = r_mul[63:32];
            end
            2'd3: begin
                w_a = r_h[63:32];
                w_b = r_mul[31:0];
            end
            default: begin
                w_a = r_h[31:0];
                w_b = r_mul[31:0];
            end
        endcase
    end

    assign w_pp  = {32'd0, w_a} * {32'd0, w_b};
    assign w_sum = r_acc + {w_pp[31:0], 32'd0};

    always_comb begin
        n_busy = r_busy;
        n_byte = r_byte;
        n_ph   = r_ph;
        n_fin  = r_fin;
        n_h    = r_h;
        n_acc  = r_acc;
        n_mul  = r_mul;
        n_done = 1'b0;
        if (!r_busy) begin
            if (i_req.start) begin
                n_busy = 1'b1;
                n_byte = 5'd0;
                n_ph   = 2'd0;
                n_fin  = 2'd0;
                n_h    = FNV_OFFSET;
            end
        end else begin
            case (r_ph)
                2'd0: begin
                    if (r_fin == 2'd0) begin
                        n_h   = r_h ^ {56'd0, w_byte};
                        n_mul = FNV_PRIME;
                    end else begin
                        n_h   = r_h ^ {32'd0, r_h[63:32]};
                        n_mul = MIX_MULT;
                    end
                    n_ph = 2'd1;
                end
                2'd1: begin
                    n_acc = w_pp;
                    n_ph  = 2'd2;
                end
                2'd2: begin
                    n_acc = w_sum;
                    n_ph  = 2'd3;
                end
                default: begin
                    n_ph = 2'd0;
                    if (r_fin == 2'd0) begin
                        n_h = w_sum;
                        if (r_byte == 5'd19) begin
                            n_fin = 2'd1;
                        end else begin
                            n_byte = r_byte + 5'd1;
                        end
                    end else begin
                        n_h    = w_sum ^ {32'd0, w_sum[63:32]};
                        n_busy = 1'b0;
                        n_done = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_byte <= n_byte;
        r_ph   <= n_ph;
        r_fin  <= n_fin;
        r_h    <= n_h;
        r_acc  <= n_acc;
        r_mul  <= n_mul;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.hash = r_h;

endmodule

### rtl/address_flag_hash_table.sv
// Address flag hash table: open-addressing set of 160-bit keys with two sticky flags.
// Depends on afht_pkg and afht_hash.
// Steps: the hash unit folds each address byte and then finalises; a lookup or commit then
// reads and compares slots in turn from the hashed slot, and a commit writes the slot it
// settles on unless the table is full. A clear sweeps every slot; the idle action goes on.
// One item at a time: the next item is taken only after the result is taken.
// Synchronous active-low reset clears the flags memory by a sweep over all 1024 slots,
// during which no item is taken.
module address_flag_hash_table (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [3:0]   i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: action[1:0], address_high[33:2], address_mid[97:34], address_low[161:98],
    //        set_originally_delegated[162], set_delegation[163], zero fill to 167.
    input  logic [167:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: was_seen[0], originally_delegated_flag[1], delegation_set_flag[2],
    //        table_full[3], zero fill to 7.
    output logic [7:0]   m_axis_tdata
);
    import afht_pkg::*;

    logic [3:0]       r_log2;
    t_state           r_state, n_state;
    logic [1:0]       r_act;
    logic [159:0]     r_key;
    logic             r_set_o, r_set_d;
    logic [IDX_W-1:0] r_slot, n_slot;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [IDX_W-1:0] w_mask;
    logic [3:0]       w_lg;
    logic [3:0]       r_res, n_res;
    logic             r_ovalid, n_ovalid;
    logic [2:0]       n_wflags;
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic [2:0]       w_wflags;
    logic             w_kwe;
    logic             r_act_rst;
    t_hash_req        w_req;
    t_hash_rsp        w_rsp;

    // Slot memories and their registered read data.
    logic [159:0]     r_keys [TABLE_DEPTH];
    logic [2:0]       r_flags [TABLE_DEPTH];
    logic [159:0]     r_rkey;
    logic [2:0]       r_rflags;

    afht_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_key   (r_key),
        .o_rsp   (w_rsp)
    );

    // Probe mask from the size register, clamped between MIN_LOG2 and the memory depth.
    always_comb begin
        w_lg = (r_log2 < MIN_LOG2) ? MIN_LOG2 : r_log2;
        if (w_lg > 4'(IDX_W)) begin
            w_lg = 4'(IDX_W);
        end
        w_mask = IDX_W'((CNT_W'(1) << w_lg) - CNT_W'(1));
    end

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'd0, r_res};
    assign w_req.start   = (r_state == S_IDLE) && s_axis_tvalid && !r_ovalid
                           && (s_axis_tdata[1:0] == ACT_LOOKUP
                               || s_axis_tdata[1:0] == ACT_COMMIT);

    // Sequencer.
    always_comb begin
        n_state  = r_state;
        n_slot   = r_slot;
        n_cnt    = r_cnt;
        n_res    = r_res;
        n_ovalid = r_ovalid;
        w_we     = 1'b0;
        w_kwe    = 1'b0;
        w_waddr  = r_slot;
        w_wflags = 3'd0;
        n_wflags = r_rflags | {r_set_d, r_set_o, 1'b1};
        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid && !r_ovalid) begin
                    n_res = 4'd0;
                    n_cnt = '0;
                    n_slot = '0;
                    unique case (t_action'(s_axis_tdata[1:0]))
                        ACT_CLEAR:  n_state = S_SWEEP;
                        ACT_LOOKUP,
                        ACT_COMMIT: n_state = S_HASH;
                        ACT_NONE:   n_state = S_OUT;
                        default:    n_state = S_OUT;
                    endcase
                end
            end
            S_HASH: begin
                if (w_rsp.done) begin
                    n_slot  = w_rsp.hash[IDX_W-1:0] & w_mask;
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_CMP;
            S_CMP: begin
                if (!r_rflags[0]) begin
                    if (r_act == ACT_COMMIT) begin
                        n_state = S_WRITE;
                    end else begin
                        n_state = S_OUT;
                    end
                end else if (r_rkey == r_key) begin
                    if (r_act == ACT_COMMIT) begin
                        n_state = S_WRITE;
                    end else begin
                        n_res   = {1'b0, r_rflags[2:1], 1'b1};
                        n_state = S_OUT;
                    end
                end else if (r_cnt == {1'b0, w_mask}) begin
                    n_res   = (r_act == ACT_COMMIT) ? 4'b1000 : 4'd0;
                    n_state = S_OUT;
                end else begin
                    n_cnt   = r_cnt + CNT_W'(1);
                    n_slot  = (r_slot + IDX_W'(1)) & w_mask;
                    n_state = S_READ;
                end
            end
            S_WRITE: begin
                // A free slot's flags read as all zero and its key is written, so this covers insert and update.
                if (!r_rflags[0]) begin
                    n_wflags = {r_set_d, r_set_o, 1'b1};
                end
                w_we     = 1'b1;
                w_kwe    = !r_rflags[0];
                w_wflags = n_wflags;
                n_res    = {1'b0, n_wflags[2:1], 1'b1};
                n_state  = S_OUT;
            end
            S_SWEEP: begin
                w_we     = 1'b1;
                w_wflags = 3'd0;
                n_slot   = r_slot + IDX_W'(1);
                if (r_slot == IDX_W'(TABLE_DEPTH - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                n_ovalid = 1'b1;
                n_state  = S_WAIT;
            end
            S_WAIT: begin
                if (!r_ovalid) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer and interface registers. The key is held as high, mid, low from the
    // top bits down, so the hash walks it most significant byte first.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_SWEEP;
            r_ovalid <= 1'b0;
            r_log2   <= RESET_LOG2;
            r_slot   <= '0;
            r_res    <= 4'd0;
        end else begin
            r_state  <= (r_state == S_SWEEP && n_state == S_OUT && r_act_rst) ? S_IDLE
                        : n_state;
            r_ovalid <= n_ovalid;
            r_slot   <= n_slot;
            r_res    <= n_res;
            if (i_cfg_we) begin
                r_log2 <= i_cfg_wdata;
            end
        end
        r_cnt <= n_cnt;
        if (s_axis_tready && s_axis_tvalid) begin
            r_act   <= s_axis_tdata[1:0];
            r_key   <= {s_axis_tdata[33:2], s_axis_tdata[97:34], s_axis_tdata[161:98]};
            r_set_o <= s_axis_tdata[162];
            r_set_d <= s_axis_tdata[163];
        end
    end

    // Marks the sweep that follows reset, which produces no result item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_rst <= 1'b1;
        end else if (r_state == S_IDLE) begin
            r_act_rst <= 1'b0;
        end
    end

    // Slot memories: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_flags[w_waddr] <= w_wflags;
        end
        if (w_kwe) begin
            r_keys[w_waddr] <= r_key;
        end
        r_rflags <= r_flags[n_slot];
        r_rkey   <= r_keys[n_slot];
    end

`ifndef SYNTHESIS
    // No item is taken while a result waits.
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !s_axis_tready)
        else $error("input taken while result pending");

    // A result appears only after the output state.
    a_out_from_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == S_OUT))
        else $error("result without output state");

    // Table full is never reported together with a hit.
    a_full_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[3] && m_axis_tdata[0]))
        else $error("full and seen together");
`endif

endmodule
